[rtl/tws_pkg.sv]
package tws_pkg;

	// Field widths of the request and result items
	localparam int COL_W   = 11;
	localparam int FRAC_W  = 16;
	localparam int DIST_W  = 16;
	localparam int TEX_W   = 10;
	localparam int TEXC_W  = 11;
	localparam int ROWO_W  = 9;
	localparam int ROW_W   = 10;
	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 40;

	// Configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 11;
	localparam logic [CFG_IDX_W-1:0] CFG_TEX_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TEX_HEIGHT = 1'd1;
	localparam logic [TEXC_W-1:0] TEX_RESET = 11'd64;
	localparam logic [TEXC_W-1:0] TEX_MAX   = 11'd1024;

	// Request kinds
	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	// Nearest allowed distance, about 0.01 in Q8.8
	localparam logic [DIST_W-1:0] MIN_DIST = 16'd3;

	localparam int DEF_SCREEN_HEIGHT = 512;

	// Serial divider: numerator is screen height << 8 or texture height << 16
	localparam int DIV_W = TEXC_W + 16;
	localparam int MUL_W = 32;
	localparam int MPL_W = 16;
	localparam int CNT_W = 5;

	// Raise a zero texture size to one, lower an oversized one to the maximum
	function automatic logic [TEXC_W-1:0] clamp_tex(input logic [TEXC_W-1:0] v);
		logic [TEXC_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = 11'd1;
		end else if (v > TEX_MAX) begin
			r = TEX_MAX;
		end
		return r;
	endfunction

endpackage

[rtl/textured_wall_column_stepper_core.sv]
// Load request: bit-serial division for the wall height, the texture column
// product alongside, a setup step, the texture step division, a multiplier load,
// shift-add steps for the start position; an empty slice ends at setup. Tick:
// one per cycle when idle and no result stalls; registered, visible next cycle.
// Reset (arst_n low, asynchronous) clears control state and sets both texture
// sizes to 64; no slice is active after reset.
module textured_wall_column_stepper_core #(
	parameter int SCREEN_HEIGHT = tws_pkg::DEF_SCREEN_HEIGHT
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// column, wall_frac, side, dir_x_negative, dir_y_positive, distance, zero pad
	input  logic [tws_pkg::IN_DATA_W-1:0] s_axis_tdata,
	// kind
	input  logic s_axis_tuser,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// out_column, row, tex_x, tex_y
	output logic [tws_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	output logic m_axis_tlast,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [tws_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tws_pkg::CFG_DATA_W-1:0] cfg_data
);
	import tws_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV_H,
		ST_CALC,
		ST_DIV_S,
		ST_STEP,
		ST_MUL_P
	} state_t;

	localparam logic [DIV_W-1:0] HGT_NUM = DIV_W'(SCREEN_HEIGHT * 256);
	localparam logic [16:0] HALF = 17'(SCREEN_HEIGHT / 2);
	localparam logic [16:0] SCR_H = 17'(SCREEN_HEIGHT);
	localparam logic [ROW_W-1:0] ROW_MAX = ROW_W'(SCREEN_HEIGHT - 1);
	localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_W - 1);
	localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(MPL_W - 1);

	state_t state_q;
	logic [TEXC_W-1:0] tex_width_q, tex_height_q;
	logic active_q;
	logic [COL_W-1:0] cur_column_q;
	logic [TEX_W-1:0] cur_tex_x_q;
	logic [ROW_W-1:0] cur_row_q, end_row_q;
	logic [31:0] tex_step_q, tex_pos_q;
	logic mirror_q;
	logic [CNT_W-1:0] cnt_q;

	// Divider and multiplier shift registers
	logic [DIV_W-1:0] num_q;
	logic [DIST_W-1:0] den_q, rem_q;
	logic [MUL_W-1:0] mcand_q, mulacc_q;
	logic [MPL_W-1:0] mplier_q;

	// Result register
	logic m_valid_q, m_last_q;
	logic [COL_W-1:0] o_col_q;
	logic [ROWO_W-1:0] o_row_q;
	logic [TEX_W-1:0] o_tx_q, o_ty_q;

	// Request field unpacking
	logic [COL_W-1:0] in_column;
	logic [FRAC_W-1:0] in_frac;
	logic in_side, in_xneg, in_ypos;
	logic [DIST_W-1:0] in_dist;
	assign in_column = s_axis_tdata[10:0];
	assign in_frac   = s_axis_tdata[26:11];
	assign in_side   = s_axis_tdata[27];
	assign in_xneg   = s_axis_tdata[28];
	assign in_ypos   = s_axis_tdata[29];
	assign in_dist   = s_axis_tdata[45:30];

	logic in_fire;
	logic emit;
	assign s_axis_tready = (state_q == ST_IDLE) && (!m_valid_q || m_axis_tready);
	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign cfg_ready = 1'b1;

	// Emit a pixel on an accepted tick of an active slice
	assign emit = in_fire && (s_axis_tuser == KIND_TICK) && active_q;

	// One restoring divider step
	logic [DIST_W+1:0] div_diff;
	logic div_qbit;
	logic [DIST_W-1:0] rem_next;
	always_comb begin
		div_diff = {1'b0, rem_q, num_q[DIV_W-1]} - {2'b00, den_q};
		div_qbit = !div_diff[DIST_W+1];
		rem_next = div_qbit ? div_diff[DIST_W-1:0] : {rem_q[DIST_W-2:0], num_q[DIV_W-1]};
	end

	// One shift-add multiplier step
	logic [MUL_W-1:0] acc_next;
	assign acc_next = mulacc_q + (mplier_q[0] ? mcand_q : '0);

	// Slice setup from the wall height
	logic [TEXC_W-1:0] w_cl, h_cl, h_m1;
	logic [15:0] height;
	logic [16:0] hh, end_sum;
	logic start_neg;
	logic [ROW_W-1:0] start_row, end_row;
	logic [MPL_W-1:0] offs;
	logic [TEX_W-1:0] tx_raw;
	logic [TEXC_W-1:0] tx_mir;
	logic slice_ok;
	always_comb begin
		w_cl = clamp_tex(tex_width_q);
		h_cl = clamp_tex(tex_height_q);
		h_m1 = h_cl - 11'd1;
		height = num_q[15:0];
		hh = {2'b00, height[15:1]};
		start_neg = hh > HALF;
		start_row = start_neg ? '0 : ROW_W'(HALF - hh);
		end_sum = HALF + hh;
		end_row = (end_sum >= SCR_H) ? ROW_MAX : end_sum[ROW_W-1:0];
		offs = start_neg ? MPL_W'(hh - HALF) : '0;
		tx_raw = mulacc_q[25:16];
		tx_mir = w_cl - {1'b0, tx_raw} - 11'd1;
		slice_ok = end_row > start_row;
	end

	// Pixel output from the running texture position
	logic [15:0] pos_hi;
	logic [TEX_W-1:0] tex_y;
	logic fin;
	always_comb begin
		pos_hi = tex_pos_q[31:16];
		tex_y = (pos_hi >= {5'b0, h_m1}) ? h_m1[TEX_W-1:0] : pos_hi[TEX_W-1:0];
		fin = ({1'b0, cur_row_q} + 11'd1) >= {1'b0, end_row_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			tex_width_q <= TEX_RESET;
			tex_height_q <= TEX_RESET;
			active_q <= 1'b0;
			cur_column_q <= '0;
			cur_tex_x_q <= '0;
			cur_row_q <= '0;
			end_row_q <= '0;
			tex_step_q <= '0;
			tex_pos_q <= '0;
			mirror_q <= 1'b0;
			cnt_q <= '0;
			m_valid_q <= 1'b0;
		end else begin
			// Configuration writes
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_TEX_WIDTH:  tex_width_q <= cfg_data;
					CFG_TEX_HEIGHT: tex_height_q <= cfg_data;
					default: ;
				endcase
			end

			// Raise the result on a new pixel, drop it once taken
			if (emit) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_fire && s_axis_tuser == KIND_LOAD) begin
						// Start the height division and the texture column product
						cur_column_q <= in_column;
						mirror_q <= (!in_side && in_xneg) || (in_side && in_ypos);
						active_q <= 1'b0;
						num_q <= HGT_NUM;
						den_q <= (in_dist < MIN_DIST) ? MIN_DIST : in_dist;
						rem_q <= '0;
						mcand_q <= MUL_W'(in_frac);
						mplier_q <= MPL_W'(w_cl);
						mulacc_q <= '0;
						cnt_q <= '0;
						state_q <= ST_DIV_H;
					end else if (emit) begin
						// Emit one pixel and advance
						o_col_q <= cur_column_q;
						o_row_q <= cur_row_q[ROWO_W-1:0];
						o_tx_q <= cur_tex_x_q;
						o_ty_q <= tex_y;
						m_last_q <= fin;
						tex_pos_q <= tex_pos_q + tex_step_q;
						cur_row_q <= cur_row_q + 10'd1;
						if (fin) begin
							active_q <= 1'b0;
						end
					end
				end
				ST_DIV_H: begin
					num_q <= {num_q[DIV_W-2:0], div_qbit};
					rem_q <= rem_next;
					mulacc_q <= acc_next;
					mcand_q <= {mcand_q[MUL_W-2:0], 1'b0};
					mplier_q <= {1'b0, mplier_q[MPL_W-1:1]};
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == DIV_LAST) begin
						state_q <= ST_CALC;
					end
				end
				ST_CALC: begin
					cur_tex_x_q <= mirror_q ? tx_mir[TEX_W-1:0] : tx_raw;
					cnt_q <= '0;
					if (slice_ok) begin
						cur_row_q <= start_row;
						end_row_q <= end_row;
						num_q <= {h_cl, 16'h0000};
						den_q <= height;
						rem_q <= '0;
						mplier_q <= offs;
						state_q <= ST_DIV_S;
					end else begin
						cur_row_q <= '0;
						end_row_q <= '0;
						tex_step_q <= '0;
						tex_pos_q <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_DIV_S: begin
					num_q <= {num_q[DIV_W-2:0], div_qbit};
					rem_q <= rem_next;
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == DIV_LAST) begin
						state_q <= ST_STEP;
					end
				end
				ST_STEP: begin
					tex_step_q <= 32'(num_q);
					mcand_q <= MUL_W'(num_q);
					mulacc_q <= '0;
					cnt_q <= '0;
					state_q <= ST_MUL_P;
				end
				ST_MUL_P: begin
					mulacc_q <= acc_next;
					mcand_q <= {mcand_q[MUL_W-2:0], 1'b0};
					mplier_q <= {1'b0, mplier_q[MPL_W-1:1]};
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == MUL_LAST) begin
						tex_pos_q <= acc_next;
						active_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tlast = m_last_q;
	assign m_axis_tdata = {o_ty_q, o_tx_q, o_row_q, o_col_q};

`ifndef SYNTHESIS
	a_busy_inactive: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !active_q)
		else $error("slice active during setup");

	a_row_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (cur_row_q < end_row_q))
		else $error("active slice past its end row");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && s_axis_tuser == KIND_TICK && active_q && fin) |=> !active_q)
		else $error("slice still active after last pixel");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(in_fire && s_axis_tuser == KIND_TICK && active_q))
		else $error("result without an active tick");
`endif

endmodule

[tb/sv/textured_wall_column_stepper_core_tb.sv]
module textured_wall_column_stepper_core_tb;

	import tws_pkg::*;

	localparam int SCR_H       = DEF_SCREEN_HEIGHT;
	localparam int CYCLE_LIMIT = 1000000;
	// A load request runs inside the block with nothing to show for it
	localparam int LOAD_SETTLE = 150;

	typedef struct packed {
		logic [COL_W-1:0]  column;
		logic [ROWO_W-1:0] row;
		logic [TEX_W-1:0]  tex_x;
		logic [TEX_W-1:0]  tex_y;
		logic              last;
	} pixel_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_DATA_W-1:0] s_axis_tdata = '0;
	logic s_axis_tuser = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic m_axis_tlast;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Column stepper model state
	logic [TEXC_W-1:0] tex_w_reg = TEX_RESET;
	logic [TEXC_W-1:0] tex_h_reg = TEX_RESET;
	logic              mdl_active = 1'b0;
	logic [COL_W-1:0]  mdl_col = '0;
	logic [TEX_W-1:0]  mdl_tex_x = '0;
	logic [ROW_W-1:0]  mdl_row = '0;
	logic [ROW_W-1:0]  mdl_end = '0;
	logic [31:0]       mdl_step = '0;
	logic [31:0]       mdl_pos = '0;

	pixel_t pixel_q[$];

	int errors = 0;
	int n_loads = 0;
	int n_pixels = 0;
	int n_settings = 0;
	int useful_items = 0;
	int cycle_cnt = 0;

	// Sender bursts and receiver pattern
	bit gaps_on = 1'b1;
	int burst_left = 0;
	bit rx_free = 1'b0;
	int rx_mode = 0;
	int rx_phase = 0;
	int hold_req = 0;
	int hold_left = 0;

	textured_wall_column_stepper_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Count down a long receiver hold-off
	always @(posedge clk) begin
		if (hold_req != 0) begin
			hold_left <= hold_req;
			hold_req = 0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Drive the receiver ready on a pattern that changes mode every so often
	always @(posedge clk) begin
		if (rx_phase == 0) begin
			rx_mode = $urandom_range(0, 2);
			rx_phase = $urandom_range(20, 120);
		end else begin
			rx_phase--;
		end
		if (hold_left != 0) begin
			m_axis_tready <= 1'b0;
		end else if (rx_free || rx_mode == 0) begin
			m_axis_tready <= 1'b1;
		end else if (rx_mode == 1) begin
			m_axis_tready <= ($urandom_range(0, 3) != 0);
		end else begin
			m_axis_tready <= ($urandom_range(0, 9) < 3);
		end
	end

	function automatic logic [TEXC_W-1:0] tex_limit(input logic [TEXC_W-1:0] v);
		if (v == '0)
			return 11'd1;
		if (v > 11'd1024)
			return 11'd1024;
		return v;
	endfunction

	function automatic logic [IN_DATA_W-1:0] pack_desc(input logic [COL_W-1:0] col,
			input logic [FRAC_W-1:0] frac, input logic side, input logic xneg,
			input logic ypos, input logic [DIST_W-1:0] wall_dist);
		return {2'b00, wall_dist, ypos, xneg, side, frac, col};
	endfunction

	// Set up a new wall slice from a descriptor request
	function automatic void load_slice(input logic [IN_DATA_W-1:0] d);
		logic [COL_W-1:0] col;
		logic [FRAC_W-1:0] frac;
		logic [DIST_W-1:0] wall_dist;
		logic side, xneg, ypos;
		int unsigned w, h, dv, height, hh;
		int start, stop;
		longint unsigned tx, offs;
		col = d[10:0];
		frac = d[26:11];
		side = d[27];
		xneg = d[28];
		ypos = d[29];
		wall_dist = d[45:30];
		w = tex_limit(tex_w_reg);
		h = tex_limit(tex_h_reg);
		dv = (wall_dist < MIN_DIST) ? MIN_DIST : wall_dist;
		height = (SCR_H * 256) / dv;
		hh = height / 2;
		start = SCR_H / 2 - int'(hh);
		if (start < 0)
			start = 0;
		stop = SCR_H / 2 + int'(hh);
		if (stop >= SCR_H)
			stop = SCR_H - 1;
		tx = (longint'(frac) * w) >> 16;
		// Mirror the texture column for the flipped hit orientations
		if ((!side && xneg) || (side && ypos))
			tx = w - tx - 1;
		mdl_col = col;
		mdl_tex_x = tx[9:0];
		if (height > 0 && stop > start) begin
			mdl_step = 32'((longint'(h) << 16) / height);
			offs = longint'(start - SCR_H / 2 + int'(hh));
			mdl_pos = 32'(offs * mdl_step);
			mdl_row = start[9:0];
			mdl_end = stop[9:0];
			mdl_active = 1'b1;
		end else begin
			mdl_step = '0;
			mdl_pos = '0;
			mdl_row = '0;
			mdl_end = '0;
			mdl_active = 1'b0;
		end
		n_loads++;
	endfunction

	// Emit the next pixel of the active slice, if any
	function automatic void next_pixel();
		int unsigned h, ty;
		logic fin;
		pixel_t px;
		if (!mdl_active)
			return;
		h = tex_limit(tex_h_reg);
		ty = mdl_pos >> 16;
		if (ty >= h)
			ty = h - 1;
		fin = (int'(mdl_row) + 1 >= int'(mdl_end));
		px.column = mdl_col;
		px.row = mdl_row[8:0];
		px.tex_x = mdl_tex_x;
		px.tex_y = ty[9:0];
		px.last = fin;
		pixel_q.push_back(px);
		mdl_pos = mdl_pos + mdl_step;
		mdl_row = mdl_row + 1'b1;
		if (fin)
			mdl_active = 1'b0;
	endfunction

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		errors++;
		if (errors <= 30)
			$display("mismatch %s: got %0d, want %0d at cycle %0d", what, got, want, cycle_cnt);
	endtask

	// Compare each delivered pixel with the oldest predicted one
	always @(posedge clk) begin : check_pixels
		pixel_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			if (pixel_q.size() == 0) begin
				report_mismatch("pixel with none pending, column", m_axis_tdata[10:0], 0);
			end else begin
				want = pixel_q.pop_front();
				n_pixels++;
				if (m_axis_tdata[10:0] != want.column)
					report_mismatch("out_column", m_axis_tdata[10:0], want.column);
				if (m_axis_tdata[19:11] != want.row)
					report_mismatch("row", m_axis_tdata[19:11], want.row);
				if (m_axis_tdata[29:20] != want.tex_x)
					report_mismatch("tex_x", m_axis_tdata[29:20], want.tex_x);
				if (m_axis_tdata[39:30] != want.tex_y)
					report_mismatch("tex_y", m_axis_tdata[39:30], want.tex_y);
				if (m_axis_tlast != want.last)
					report_mismatch("last", m_axis_tlast, want.last);
			end
		end
	end

	// Offer one request, wait for it to be taken, then update the model
	task automatic send_req(input logic kind, input logic [IN_DATA_W-1:0] data);
		int gap;
		if (gaps_on && burst_left == 0) begin
			gap = $urandom_range(0, 12);
			burst_left = $urandom_range(1, 24);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= data;
		s_axis_tuser <= kind;
		do @(posedge clk); while (!s_axis_tready);
		if (burst_left > 0)
			burst_left--;
		if (kind == KIND_LOAD) begin
			useful_items++;
			load_slice(data);
		end else begin
			if (mdl_active)
				useful_items++;
			next_pixel();
		end
	endtask

	task automatic send_tick();
		send_req(KIND_TICK, IN_DATA_W'({$urandom, $urandom}));
	endtask

	// Drain everything, including a load still being worked out
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (pixel_q.size() != 0) @(posedge clk);
		repeat (LOAD_SETTLE) @(posedge clk);
	endtask

	task automatic write_tex_sizes(input logic [TEXC_W-1:0] w, input logic [TEXC_W-1:0] h);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_TEX_WIDTH;
		cfg_data <= w;
		do @(posedge clk); while (!cfg_ready);
		tex_w_reg = w;
		cfg_index <= CFG_TEX_HEIGHT;
		cfg_data <= h;
		do @(posedge clk); while (!cfg_ready);
		tex_h_reg = h;
		cfg_valid <= 1'b0;
		n_settings++;
	endtask

	// Random slices: mostly whole slices, some cut short, some trailing idle ticks
	task automatic run_slices(input int n);
		int target, cut, cnt, pick;
		logic [DIST_W-1:0] wall_dist;
		bit broken;
		target = useful_items + n;
		while (useful_items < target) begin
			pick = $urandom_range(0, 9);
			if (pick == 0)
				wall_dist = DIST_W'($urandom_range(0, 65535));
			else if (pick < 3)
				wall_dist = DIST_W'($urandom_range(256, 2047));
			else
				wall_dist = DIST_W'($urandom_range(1024, 65535));
			send_req(KIND_LOAD, pack_desc(COL_W'($urandom_range(0, 2047)),
				FRAC_W'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), wall_dist));
			broken = ($urandom_range(0, 9) < 2);
			cut = $urandom_range(0, 40);
			cnt = 0;
			while (mdl_active && !(broken && cnt >= cut)) begin
				send_tick();
				cnt++;
			end
			if ($urandom_range(0, 4) == 0)
				repeat ($urandom_range(1, 2)) send_tick();
		end
	endtask

	// Extreme distances, mirroring cases, replacing an active slice, idle ticks
	task automatic test_directed();
		send_tick();
		send_req(KIND_LOAD, pack_desc(11'd0, 16'h0000, 1'b0, 1'b0, 1'b0, 16'd0));
		repeat (3) send_tick();
		send_req(KIND_LOAD, pack_desc(11'd2047, 16'hFFFF, 1'b0, 1'b1, 1'b0, 16'd3));
		repeat (2) send_tick();
		send_req(KIND_LOAD, pack_desc(11'd1024, 16'h8000, 1'b1, 1'b0, 1'b1, 16'hFFFF));
		repeat (3) send_tick();
		send_req(KIND_LOAD, pack_desc(11'd5, 16'h0001, 1'b1, 1'b1, 1'b0, 16'd256));
		repeat (2) send_tick();
		send_req(KIND_LOAD, pack_desc(11'd1, 16'h7FFF, 1'b0, 1'b0, 1'b1, 16'hFFFE));
		repeat (3) send_tick();
	endtask

	// Zero and oversized texture sizes as well as the legal extremes
	task automatic test_size_extremes();
		logic [TEXC_W-1:0] ws[5] = '{11'd0, 11'd2047, 11'd1, 11'd1024, 11'd1025};
		logic [TEXC_W-1:0] hs[5] = '{11'd0, 11'd2047, 11'd1024, 11'd1, 11'd3};
		for (int i = 0; i < 5; i++) begin
			wait_idle();
			write_tex_sizes(ws[i], hs[i]);
			run_slices(80);
		end
	endtask

	task automatic test_random_sizes();
		repeat (3) begin
			wait_idle();
			write_tex_sizes(TEXC_W'($urandom_range(1, 1024)),
				TEXC_W'($urandom_range(1, 1024)));
			run_slices(200);
		end
	endtask

	// Hold the receiver off long enough for the block to stall its input
	task automatic test_backpressure();
		wait_idle();
		write_tex_sizes(TEXC_W'($urandom_range(0, 2047)), TEXC_W'($urandom_range(0, 2047)));
		gaps_on = 1'b0;
		hold_req = 400;
		run_slices(150);
		gaps_on = 1'b1;
	endtask

	task automatic test_full_rate();
		wait_idle();
		write_tex_sizes(11'd64, 11'd64);
		gaps_on = 1'b0;
		rx_free = 1'b1;
		run_slices(250);
		gaps_on = 1'b1;
		rx_free = 1'b0;
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_size_extremes();
		test_random_sizes();
		test_backpressure();
		test_full_rate();
		wait_idle();
		if (pixel_q.size() != 0)
			report_mismatch("pixels never delivered", 0, pixel_q.size());
		$display("covered %0d slice loads and %0d pixels over %0d texture size settings",
			n_loads, n_pixels, n_settings);
		$display("including sizes out of range, full-screen and two-row slices, long stall");
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
